[design/mbrp_pkg.sv]
// ----------------------------------------------------------------------------
// mbrp_pkg: battery reply parser shared types and constants
// Transfer payload types, frame constants and the bytewise Modbus CRC-16.
// ----------------------------------------------------------------------------
package mbrp_pkg;

    localparam logic [7:0]  HDR_ADDR      = 8'h01;
    localparam logic [7:0]  HDR_FUNC      = 8'h03;
    localparam logic [7:0]  HDR_LEN       = 8'd14;
    localparam logic [4:0]  POS_VOLT_HI   = 5'd3;
    localparam logic [4:0]  POS_VOLT_LO   = 5'd4;
    localparam logic [4:0]  POS_CURR_HI   = 5'd5;
    localparam logic [4:0]  POS_CURR_LO   = 5'd6;
    localparam logic [4:0]  POS_CHARGE    = 5'd16;
    localparam logic [4:0]  CRC_SPAN      = 5'd17;
    localparam logic [4:0]  POS_CRC_HI    = 5'd18;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [9:0]  IDLE_LIMIT_RST = 10'd100;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_IDLE = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic               frame_ok;
        logic [15:0]        voltage;
        logic signed [15:0] current;
        logic [7:0]         charge_level;
    } out_item_t;

    typedef enum logic [3:0] {
        PH_ADDR    = 4'b0001,
        PH_FUNC    = 4'b0010,
        PH_LEN     = 4'b0100,
        PH_PAYLOAD = 4'b1000
    } phase_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

[design/modbus_battery_reply_parser_core.sv]
// The transfer that completes a frame passes the input register, and its result is then
// held in the result register.
// Throughput: one item per cycle; the bytewise CRC update is a combinational XOR network.
// The parse stage stalls only while the result register holds an untaken result.
// Reset (rst_n low, asynchronous): parser waits for the start byte, CRC 0xFFFF,
// held values zero, idle limit 100.
// ----------------------------------------------------------------------------
// modbus_battery_reply_parser_core
// Parses fixed 19-byte Modbus RTU read replies and reports held battery data.
// ----------------------------------------------------------------------------
module modbus_battery_reply_parser_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mbrp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mbrp_pkg::out_item_t out_data,
    input  logic                cfg_wr_en,
    input  logic [9:0]          cfg_wr_data
);
    import mbrp_pkg::*;

    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    logic [9:0]  idle_limit_reg;

    phase_t      phase_reg,         phase_next;
    logic [4:0]  byte_count_reg,    byte_count_next;
    logic [9:0]  idle_count_reg,    idle_count_next;
    logic [15:0] crc_reg,           crc_next;
    logic [15:0] frame_volt_reg,    frame_volt_next;
    logic [15:0] frame_curr_reg,    frame_curr_next;
    logic [7:0]  frame_charge_reg,  frame_charge_next;
    logic [7:0]  crc_low_reg,       crc_low_next;
    logic [15:0] held_volt_reg,     held_volt_next;
    logic [15:0] held_curr_reg,     held_curr_next;
    logic [7:0]  held_charge_reg,   held_charge_next;

    logic        advance;
    logic        fire;
    logic        emit;
    logic        crc_ok;
    logic [15:0] crc_upd;
    logic [9:0]  idle_inc;
    logic [7:0]  b;

    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    assign b        = in_item_reg.rx_byte;
    assign crc_upd  = crc16_byte((phase_reg == PH_ADDR) ? CRC_INIT : crc_reg, b);
    assign idle_inc = idle_count_reg + 10'd1;
    assign crc_ok   = (crc_reg[7:0] == crc_low_reg) && (crc_reg[15:8] == b);

    always_comb
    begin
        phase_next        = phase_reg;
        byte_count_next   = byte_count_reg;
        idle_count_next   = idle_count_reg;
        crc_next          = crc_reg;
        frame_volt_next   = frame_volt_reg;
        frame_curr_next   = frame_curr_reg;
        frame_charge_next = frame_charge_reg;
        crc_low_next      = crc_low_reg;
        held_volt_next    = held_volt_reg;
        held_curr_next    = held_curr_reg;
        held_charge_next  = held_charge_reg;
        emit              = 1'b0;

        if (in_item_reg.cmd == CMD_IDLE) begin
            idle_count_next = idle_inc;
            if (idle_inc >= idle_limit_reg) begin
                idle_count_next = '0;
                phase_next      = PH_ADDR;
                byte_count_next = '0;
            end
        end else begin
            idle_count_next = '0;
            case (phase_reg)
                PH_ADDR:
                begin
                    if (b == HDR_ADDR) begin
                        phase_next      = PH_FUNC;
                        byte_count_next = 5'd1;
                        crc_next        = crc_upd;
                    end
                end
                PH_FUNC:
                begin
                    if (b == HDR_FUNC) begin
                        phase_next      = PH_LEN;
                        byte_count_next = 5'd2;
                        crc_next        = crc_upd;
                    end else begin
                        phase_next = PH_ADDR;
                    end
                end
                PH_LEN:
                begin
                    if (b == HDR_LEN) begin
                        phase_next      = PH_PAYLOAD;
                        byte_count_next = 5'd3;
                        crc_next        = crc_upd;
                    end else begin
                        phase_next = PH_ADDR;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (byte_count_reg < CRC_SPAN) begin
                        crc_next = crc_upd;
                    end
                    if (byte_count_reg == POS_VOLT_HI) frame_volt_next = {b, 8'h00};
                    if (byte_count_reg == POS_VOLT_LO) frame_volt_next = {frame_volt_reg[15:8], b};
                    if (byte_count_reg == POS_CURR_HI) frame_curr_next = {b, 8'h00};
                    if (byte_count_reg == POS_CURR_LO) frame_curr_next = {frame_curr_reg[15:8], b};
                    if (byte_count_reg == POS_CHARGE)  frame_charge_next = b;
                    if (byte_count_reg == CRC_SPAN)    crc_low_next = b;
                    byte_count_next = byte_count_reg + 5'd1;
                    if (byte_count_reg >= POS_CRC_HI) begin
                        emit            = 1'b1;
                        phase_next      = PH_ADDR;
                        byte_count_next = '0;
                        if (crc_ok) begin
                            held_volt_next   = frame_volt_reg;
                            held_curr_next   = frame_curr_reg;
                            held_charge_next = frame_charge_reg;
                        end
                    end
                end
                default:
                begin
                    phase_next      = PH_ADDR;
                    byte_count_next = '0;
                end
            endcase
        end
    end

    // hold the item until the parse stage can advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            in_item_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idle_limit_reg   <= IDLE_LIMIT_RST;
            phase_reg        <= PH_ADDR;
            byte_count_reg   <= '0;
            idle_count_reg   <= '0;
            crc_reg          <= CRC_INIT;
            frame_volt_reg   <= '0;
            frame_curr_reg   <= '0;
            frame_charge_reg <= '0;
            crc_low_reg      <= '0;
            held_volt_reg    <= '0;
            held_curr_reg    <= '0;
            held_charge_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                idle_limit_reg <= cfg_wr_data;
            end
            if (fire) begin
                phase_reg        <= phase_next;
                byte_count_reg   <= byte_count_next;
                idle_count_reg   <= idle_count_next;
                crc_reg          <= crc_next;
                frame_volt_reg   <= frame_volt_next;
                frame_curr_reg   <= frame_curr_next;
                frame_charge_reg <= frame_charge_next;
                crc_low_reg      <= crc_low_next;
                held_volt_reg    <= held_volt_next;
                held_curr_reg    <= held_curr_next;
                held_charge_reg  <= held_charge_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= fire && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit) begin
            out_item_reg.frame_ok     <= crc_ok;
            out_item_reg.voltage      <= held_volt_next;
            out_item_reg.current      <= held_curr_next;
            out_item_reg.charge_level <= held_charge_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule
